/* rtl/two_axis_pid_servo_tracker_defines.svh */
// Assertion macros for the two-axis PID servo tracker.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef TWO_AXIS_PID_SERVO_TRACKER_DEFINES_SVH
`define TWO_AXIS_PID_SERVO_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tpst_pkg.sv */
// Shared types, constants and command codes of the two-axis PID servo tracker.
// Used by tpst_ctrl, tpst_dp and two_axis_pid_servo_tracker.
`default_nettype none

package tpst_pkg;

    localparam int ERROR_BITS   = 12;
    localparam int PW_BITS      = 12;
    localparam int GAIN_BITS    = 48;
    localparam int MS_BITS      = 16;
    localparam int ACC_BITS     = 64;
    localparam int MUL_A_BITS   = 64;
    localparam int MUL_B_BITS   = 16;
    localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int DIV_STEPS    = 64;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_BITS = 3;

    localparam logic [PW_BITS-1:0]   CENTER_PULSE = PW_BITS'(1500);
    localparam logic [MS_BITS-1:0]   FIRST_DIVISOR = MS_BITS'(10);

    localparam logic [GAIN_BITS-1:0] KP_RESET = GAIN_BITS'(1717986918);
    localparam logic [GAIN_BITS-1:0] KI_RESET = GAIN_BITS'(43);
    localparam logic [GAIN_BITS-1:0] KD_RESET = GAIN_BITS'(42950);
    localparam logic [PW_BITS-1:0]   LOW_RESET  = PW_BITS'(500);
    localparam logic [PW_BITS-1:0]   HIGH_RESET = PW_BITS'(2500);

    localparam logic [CFG_IDX_BITS-1:0] CFG_KP         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KI         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KD         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YAW_LOW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YAW_HIGH   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH_LOW  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH_HIGH = 3'd6;

    typedef struct packed {
        logic signed [ERROR_BITS-1:0] x_err;
        logic signed [ERROR_BITS-1:0] y_err;
        logic [MS_BITS-1:0]           elapsed_ms;
    } in_t;

    typedef struct packed {
        logic [PW_BITS-1:0] yaw_pulse;
        logic [PW_BITS-1:0] pitch_pulse;
        logic               yaw_accepted;
        logic               pitch_accepted;
    } out_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] kp_gain;
        logic [GAIN_BITS-1:0] ki_gain_per_ms;
        logic [GAIN_BITS-1:0] kd_gain_ms;
        logic [PW_BITS-1:0]   yaw_low_limit;
        logic [PW_BITS-1:0]   yaw_high_limit;
        logic [PW_BITS-1:0]   pitch_low_limit;
        logic [PW_BITS-1:0]   pitch_high_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_P,
        CMD_MUL_I1,
        CMD_MUL_I2,
        CMD_DIV_LOAD_I,
        CMD_DIV_STEP,
        CMD_ACC,
        CMD_MUL_D,
        CMD_DIV_LOAD_D,
        CMD_D_SAVE,
        CMD_SUM1,
        CMD_SUM2,
        CMD_MOVE,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    axis;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic ms_zero;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/tpst_ctrl.sv */
// Sequencer of the two-axis PID servo tracker: steps one item through both axes.
// Depends on tpst_pkg; drives tpst_dp through cmd_t and reads dp_status_t.
`default_nettype none

module tpst_ctrl
    import tpst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    input  dp_status_t status,
    output cmd_t       cmd
);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_MUL_P   = 14'b00000000000010,
        ST_MUL_I1  = 14'b00000000000100,
        ST_MUL_I2  = 14'b00000000001000,
        ST_DIVI_LD = 14'b00000000010000,
        ST_DIV_I   = 14'b00000000100000,
        ST_ACC     = 14'b00000001000000,
        ST_MUL_D   = 14'b00000010000000,
        ST_DIVD_LD = 14'b00000100000000,
        ST_DIV_D   = 14'b00001000000000,
        ST_SUM1    = 14'b00010000000000,
        ST_SUM2    = 14'b00100000000000,
        ST_MOVE    = 14'b01000000000000,
        ST_FINISH  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = CMD_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    axis_next  = 1'b0;
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                cmd.op     = CMD_MUL_P;
                state_next = ST_MUL_I1;
            end
            ST_MUL_I1:
            begin
                cmd.op     = CMD_MUL_I1;
                state_next = status.first ? ST_DIVI_LD : ST_MUL_I2;
            end
            ST_MUL_I2:
            begin
                cmd.op     = CMD_MUL_I2;
                state_next = ST_ACC;
            end
            ST_DIVI_LD:
            begin
                cmd.op     = CMD_DIV_LOAD_I;
                state_next = ST_DIV_I;
            end
            ST_DIV_I:
            begin
                if (status.div_done)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    cmd.op = CMD_DIV_STEP;
                end
            end
            ST_ACC:
            begin
                cmd.op = CMD_ACC;
                // The derivative term exists only after the first item and for nonzero time.
                if (!status.first && !status.ms_zero)
                begin
                    state_next = ST_MUL_D;
                end
                else
                begin
                    state_next = ST_SUM1;
                end
            end
            ST_MUL_D:
            begin
                cmd.op     = CMD_MUL_D;
                state_next = ST_DIVD_LD;
            end
            ST_DIVD_LD:
            begin
                cmd.op     = CMD_DIV_LOAD_D;
                state_next = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                if (status.div_done)
                begin
                    cmd.op     = CMD_D_SAVE;
                    state_next = ST_SUM1;
                end
                else
                begin
                    cmd.op = CMD_DIV_STEP;
                end
            end
            ST_SUM1:
            begin
                cmd.op     = CMD_SUM1;
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                cmd.op     = CMD_SUM2;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.op = CMD_MOVE;
                if (axis_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL_P;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op     = CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tpst_dp.sv */
// Datapath of the two-axis PID servo tracker: shared 64x16 multiplier,
// radix-2 divider, per-axis state and the pulse width update. Depends on tpst_pkg.
`default_nettype none

module tpst_dp
    import tpst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  in_t        in_item,
    input  cfg_t       cfg,
    output dp_status_t status,
    output out_t       result
);

    localparam logic [ACC_BITS-2:0] MAG_MAX = '1;

    function automatic logic signed [ACC_BITS-1:0] sadd_sat(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS-1:0] s;
        s = a + b;
        if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (s[ACC_BITS-1] != a[ACC_BITS-1]))
        begin
            s = a[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, MAG_MAX};
        end
        return s;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] apply_sign(
        input logic              neg,
        input logic [ACC_BITS-2:0] mag
    );
        logic signed [ACC_BITS-1:0] v;
        v = {1'b0, mag};
        return neg ? -v : v;
    endfunction

    // Input item and per-axis state.
    in_t                        in_reg;
    logic                       started_reg;
    logic signed [ERROR_BITS-1:0] last_reg [2];
    logic signed [ACC_BITS-1:0] acc_reg [2];
    logic [PW_BITS-1:0]         pos_reg [2];
    logic                       flag_reg [2];

    // Working registers.
    logic [PROD_BITS-1:0]       prod_reg;
    logic signed [ACC_BITS-1:0] p_reg;
    logic signed [ACC_BITS-1:0] d_reg;
    logic [ACC_BITS-1:0]        dvd_reg;
    logic [MS_BITS-1:0]         rem_reg;
    logic [MS_BITS-1:0]         dsor_reg;
    logic [DIV_CNT_BITS-1:0]    cnt_reg;

    logic                         ax;
    logic signed [ERROR_BITS-1:0] e_sel;
    logic signed [ERROR_BITS-1:0] last_sel;
    logic signed [ACC_BITS-1:0]   acc_sel;
    logic [PW_BITS-1:0]           pos_sel;
    logic [PW_BITS-1:0]           low_sel;
    logic [PW_BITS-1:0]           high_sel;
    logic                         e_neg;
    logic [ERROR_BITS-1:0]        e_mag;
    logic signed [ERROR_BITS:0]   de;
    logic                         de_neg;
    logic [ERROR_BITS-1:0]        de_mag;
    logic [MUL_A_BITS-1:0]        mul_a;
    logic [MUL_B_BITS-1:0]        mul_b;
    logic [PROD_BITS-1:0]         prod_next;
    logic [ACC_BITS-2:0]          prod_sat;
    logic [ACC_BITS-2:0]          quo_sat;
    logic [MS_BITS:0]             div_trial;
    logic                         div_ge;
    logic [ACC_BITS-2:0]          inc_mag;
    logic signed [ACC_BITS-1:0]   acc_half;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic signed [31:0]           move;
    logic signed [33:0]           cand;
    logic                         cand_ok;

    assign ax       = cmd.axis;
    assign e_sel    = ax ? in_reg.y_err : in_reg.x_err;
    assign last_sel = last_reg[ax];
    assign acc_sel  = acc_reg[ax];
    assign pos_sel  = pos_reg[ax];
    assign low_sel  = ax ? cfg.pitch_low_limit : cfg.yaw_low_limit;
    assign high_sel = ax ? cfg.pitch_high_limit : cfg.yaw_high_limit;

    assign e_neg  = e_sel[ERROR_BITS-1];
    assign e_mag  = e_neg ? ERROR_BITS'(-e_sel) : ERROR_BITS'(e_sel);
    assign de     = {e_sel[ERROR_BITS-1], e_sel} - {last_sel[ERROR_BITS-1], last_sel};
    assign de_neg = de[ERROR_BITS];
    assign de_mag = de_neg ? ERROR_BITS'(-de) : ERROR_BITS'(de);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = MUL_A_BITS'(cfg.kp_gain);
        mul_b = MUL_B_BITS'(e_mag);
        case (cmd.op)
            CMD_MUL_I1:
            begin
                mul_a = MUL_A_BITS'(cfg.ki_gain_per_ms);
                mul_b = started_reg ? MUL_B_BITS'(in_reg.elapsed_ms) : MUL_B_BITS'(e_mag);
            end
            CMD_MUL_I2:
            begin
                mul_a = prod_reg[MUL_A_BITS-1:0];
                mul_b = MUL_B_BITS'(e_mag);
            end
            CMD_MUL_D:
            begin
                mul_a = MUL_A_BITS'(cfg.kd_gain_ms);
                mul_b = MUL_B_BITS'(de_mag);
            end
            default:
            begin
                mul_a = MUL_A_BITS'(cfg.kp_gain);
                mul_b = MUL_B_BITS'(e_mag);
            end
        endcase
    end

    assign prod_next = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign prod_sat  = (|prod_reg[PROD_BITS-1:ACC_BITS-1]) ? MAG_MAX : prod_reg[ACC_BITS-2:0];
    assign quo_sat   = dvd_reg[ACC_BITS-1] ? MAG_MAX : dvd_reg[ACC_BITS-2:0];

    // One quotient bit per step; the dividend shifts out as quotient bits shift in.
    assign div_trial = {rem_reg, dvd_reg[ACC_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, dsor_reg});

    assign inc_mag  = started_reg ? prod_sat : quo_sat;
    // Halving truncates toward zero, so odd negative values round up.
    assign acc_half = (acc_sel >>> 1)
                    + $signed(ACC_BITS'(acc_sel[ACC_BITS-1] & acc_sel[0]));
    assign acc_next = sadd_sat(acc_half, apply_sign(e_neg, inc_mag));

    assign move    = p_reg[ACC_BITS-1:32] + 32'(p_reg[ACC_BITS-1] & (|p_reg[31:0]));
    assign cand    = $signed({22'b0, pos_sel}) + 34'(move);
    assign cand_ok = (cand >= $signed({22'b0, low_sel})) && (cand <= $signed({22'b0, high_sel}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            last_reg[0] <= '0;
            last_reg[1] <= '0;
            acc_reg[0]  <= '0;
            acc_reg[1]  <= '0;
            pos_reg[0]  <= CENTER_PULSE;
            pos_reg[1]  <= CENTER_PULSE;
            flag_reg[0] <= 1'b0;
            flag_reg[1] <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                CMD_DIV_LOAD_I, CMD_DIV_LOAD_D:
                begin
                    cnt_reg <= DIV_CNT_BITS'(DIV_STEPS);
                end
                CMD_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
                end
                CMD_ACC:
                begin
                    acc_reg[ax] <= acc_next;
                end
                CMD_MOVE:
                begin
                    last_reg[ax] <= e_sel;
                    flag_reg[ax] <= cand_ok;
                    if (cand_ok)
                    begin
                        pos_reg[ax] <= cand[PW_BITS-1:0];
                    end
                end
                CMD_FINISH:
                begin
                    started_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                in_reg <= in_item;
            end
            CMD_MUL_P, CMD_MUL_I2, CMD_MUL_D:
            begin
                prod_reg <= prod_next;
            end
            CMD_MUL_I1:
            begin
                p_reg    <= apply_sign(e_neg, prod_sat);
                prod_reg <= prod_next;
            end
            CMD_DIV_LOAD_I:
            begin
                dvd_reg  <= {1'b0, prod_sat};
                dsor_reg <= FIRST_DIVISOR;
                rem_reg  <= '0;
            end
            CMD_DIV_LOAD_D:
            begin
                dvd_reg  <= prod_reg[ACC_BITS-1:0];
                dsor_reg <= in_reg.elapsed_ms;
                rem_reg  <= '0;
            end
            CMD_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[ACC_BITS-2:0], div_ge};
                rem_reg <= div_ge ? MS_BITS'(div_trial - {1'b0, dsor_reg})
                                  : div_trial[MS_BITS-1:0];
            end
            CMD_ACC:
            begin
                d_reg <= '0;
            end
            CMD_D_SAVE:
            begin
                d_reg <= apply_sign(de_neg, quo_sat);
            end
            CMD_SUM1:
            begin
                p_reg <= sadd_sat(p_reg, acc_sel);
            end
            CMD_SUM2:
            begin
                p_reg <= sadd_sat(p_reg, d_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign status.first    = !started_reg;
    assign status.ms_zero  = (in_reg.elapsed_ms == '0);
    assign status.div_done = (cnt_reg == '0);

    assign result.yaw_pulse      = pos_reg[0];
    assign result.pitch_pulse    = pos_reg[1];
    assign result.yaw_accepted   = flag_reg[0];
    assign result.pitch_accepted = flag_reg[1];

endmodule

`default_nettype wire

/* rtl/two_axis_pid_servo_tracker.sv */
// Top level of the two-axis PID servo tracker: configuration registers,
// output register, sequencer and datapath. Depends on tpst_pkg, tpst_ctrl, tpst_dp.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item (x_err, y_err, elapsed_ms)
// out       output     out_valid / out_ready  out_item (pulses, accepted flags)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item takes longer when it is the first after reset or when elapsed_ms is
// nonzero; the 64-step radix-2 divider, run once per axis in those cases,
// sets the time.
// One item is worked on at a time; the next item is taken while a result waits.
// A result waits in the output register; the sequencer holds before updating it.
// Reset clears the accumulators and last errors, centres both pulses and loads the default gains and limits.
`default_nettype none

`include "two_axis_pid_servo_tracker_defines.svh"

module two_axis_pid_servo_tracker
    import tpst_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_t                     in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_t                    out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]    cfg_data
);

    cfg_t       cfg_reg;
    logic       out_valid_reg;
    out_t       out_item_reg;
    logic       out_free;
    cmd_t       cmd;
    dp_status_t status;
    out_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain          <= KP_RESET;
            cfg_reg.ki_gain_per_ms   <= KI_RESET;
            cfg_reg.kd_gain_ms       <= KD_RESET;
            cfg_reg.yaw_low_limit    <= LOW_RESET;
            cfg_reg.yaw_high_limit   <= HIGH_RESET;
            cfg_reg.pitch_low_limit  <= LOW_RESET;
            cfg_reg.pitch_high_limit <= HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KP:         cfg_reg.kp_gain          <= cfg_data;
                CFG_KI:         cfg_reg.ki_gain_per_ms   <= cfg_data;
                CFG_KD:         cfg_reg.kd_gain_ms       <= cfg_data;
                CFG_YAW_LOW:    cfg_reg.yaw_low_limit    <= cfg_data[PW_BITS-1:0];
                CFG_YAW_HIGH:   cfg_reg.yaw_high_limit   <= cfg_data[PW_BITS-1:0];
                CFG_PITCH_LOW:  cfg_reg.pitch_low_limit  <= cfg_data[PW_BITS-1:0];
                CFG_PITCH_HIGH: cfg_reg.pitch_high_limit <= cfg_data[PW_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == CMD_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_FINISH)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    tpst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    tpst_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .status  (status),
        .result  (result)
    );

    `TPST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `TPST_ASSERT_NOW(a_finish_needs_room, cmd.op == CMD_FINISH, out_free, "output overwritten")
    `TPST_ASSERT_NOW(a_load_on_accept, cmd.op == CMD_LOAD, in_valid && in_ready, "load without item")

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the two-axis PID servo tracker: directed rows, then
// randomized phases under several gain and limit settings. Depends on tpst_pkg.
module tb;
    import tpst_pkg::*;

    localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_LO = 64'sh8000_0000_0000_0000;
    localparam int     DRAIN_CYCLES = 400;
    localparam int     RANDOM_PHASES = 9;
    localparam int     ITEMS_PER_PHASE = 148;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_t                     in_item;
    logic                    out_valid;
    logic                    out_ready;
    out_t                    out_item;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [GAIN_BITS-1:0]    cfg_data;

    two_axis_pid_servo_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracker state as the bench sees it.
    logic [GAIN_BITS-1:0] kp, ki, kd;
    logic [PW_BITS-1:0]   yaw_lo, yaw_hi, pitch_lo, pitch_hi;
    longint               x_last, y_last, x_acc, y_acc, yaw_pos, pitch_pos;
    bit                   started;

    out_t pulse_queue[$];
    bit   typed_next;
    out_t typed_value;
    int   fails;
    int   items_sent;
    int   results_seen;
    bit   quiet_sender;
    bit   quiet_receiver;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint add_sat(longint a, longint b);
        longint r;
        r = a + b;
        if (a > 0 && b > 0 && r < 0)
            r = SAT_HI;
        else if (a < 0 && b < 0 && r >= 0)
            r = SAT_LO;
        return r;
    endfunction

    function automatic logic [63:0] umul_sat(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        if (pr > 128'(SAT_HI))
            return 64'(SAT_HI);
        return pr[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint e);
        return (e < 0) ? 64'(-e) : 64'(e);
    endfunction

    function automatic longint signed_gain(longint e, logic [63:0] k);
        longint m;
        m = umul_sat(magnitude(e), k);
        return (e < 0) ? -m : m;
    endfunction

    // Integer move of one axis; updates that axis's accumulator and last error.
    function automatic longint axis_move(input longint e, inout longint last,
                                         inout longint acc, input bit first,
                                         input longint ms);
        longint       p, inc, d, sum;
        logic [63:0]  m, q, r, mag;
        d = 0;
        if (first)
            last = e;
        p = signed_gain(e, 64'(kp));
        if (first)
            inc = signed_gain(e, 64'(ki)) / 10;
        else
            inc = signed_gain(e, 64'(ki) * 64'(ms));
        acc = add_sat(acc / 2, inc);
        if (!first && ms != 0)
        begin
            m = magnitude(e - last);
            q = 64'(kd) / 64'(ms);
            r = 64'(kd) % 64'(ms);
            mag = umul_sat(m, q);
            if (mag > 64'(SAT_HI) - (m * r) / 64'(ms))
                mag = 64'(SAT_HI);
            else
                mag = mag + (m * r) / 64'(ms);
            d = (e - last < 0) ? -longint'(mag) : longint'(mag);
        end
        sum = add_sat(add_sat(p, acc), d);
        last = e;
        return sum / 64'sd4294967296;
    endfunction

    function automatic out_t predict_pulses(in_t v);
        out_t   o;
        longint xe, ye, ms, cy, cp, lo, hi;
        bit     first;
        xe = longint'($signed(v.x_err));
        ye = longint'($signed(v.y_err));
        ms = longint'(v.elapsed_ms);
        first = !started;
        cy = yaw_pos + axis_move(xe, x_last, x_acc, first, ms);
        cp = pitch_pos + axis_move(ye, y_last, y_acc, first, ms);
        started = 1'b1;
        lo = longint'(yaw_lo);
        hi = longint'(yaw_hi);
        o.yaw_accepted = (cy >= lo && cy <= hi);
        lo = longint'(pitch_lo);
        hi = longint'(pitch_hi);
        o.pitch_accepted = (cp >= lo && cp <= hi);
        if (o.yaw_accepted)
            yaw_pos = cy;
        if (o.pitch_accepted)
            pitch_pos = cp;
        o.yaw_pulse = yaw_pos[PW_BITS-1:0];
        o.pitch_pulse = pitch_pos[PW_BITS-1:0];
        return o;
    endfunction

    // Both channels are watched at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        out_t want;
        out_t got;
        if (rst_n && in_valid && in_ready)
        begin
            want = predict_pulses(in_item);
            if (typed_next)
                want = typed_value;
            pulse_queue.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = out_item;
            results_seen++;
            if (pulse_queue.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                fails++;
            end
            else
            begin
                want = pulse_queue.pop_front();
                if (got.yaw_pulse !== want.yaw_pulse)
                begin
                    $display("%0t: yaw_pulse expected %0d got %0d", $time,
                             want.yaw_pulse, got.yaw_pulse);
                    fails++;
                end
                if (got.pitch_pulse !== want.pitch_pulse)
                begin
                    $display("%0t: pitch_pulse expected %0d got %0d", $time,
                             want.pitch_pulse, got.pitch_pulse);
                    fails++;
                end
                if (got.yaw_accepted !== want.yaw_accepted)
                begin
                    $display("%0t: yaw_accepted expected %0b got %0b", $time,
                             want.yaw_accepted, got.yaw_accepted);
                    fails++;
                end
                if (got.pitch_accepted !== want.pitch_accepted)
                begin
                    $display("%0t: pitch_accepted expected %0b got %0b", $time,
                             want.pitch_accepted, got.pitch_accepted);
                    fails++;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= quiet_receiver || ($urandom_range(99) >= 7);

    // Leaves in_valid high after acceptance; random gaps may still drop it.
    task automatic send_item(in_t v);
        @(negedge clk);
        while (!quiet_sender && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= v;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pulse_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_KP:         kp = val;
            CFG_KI:         ki = val;
            CFG_KD:         kd = val;
            CFG_YAW_LOW:    yaw_lo = val[PW_BITS-1:0];
            CFG_YAW_HIGH:   yaw_hi = val[PW_BITS-1:0];
            CFG_PITCH_LOW:  pitch_lo = val[PW_BITS-1:0];
            CFG_PITCH_HIGH: pitch_hi = val[PW_BITS-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_BITS-1:0] rand_gain();
        logic [63:0] g;
        g = {$urandom, $urandom};
        return g[GAIN_BITS-1:0] >> $urandom_range(GAIN_BITS - 1, 0);
    endfunction

    task automatic load_setting(int phase);
        logic [GAIN_BITS-1:0] g_p, g_i, g_d;
        logic [PW_BITS-1:0]   yl, yh, pl, ph;
        logic [63:0]          junk;
        g_p = rand_gain();
        g_i = rand_gain();
        g_d = rand_gain();
        yl = PW_BITS'($urandom_range(800, 0));
        yh = PW_BITS'($urandom_range(4095, 2200));
        pl = PW_BITS'($urandom_range(800, 0));
        ph = PW_BITS'($urandom_range(4095, 2200));
        case (phase)
            0:
            begin
                g_p = KP_RESET;
                g_i = KI_RESET;
                g_d = KD_RESET;
            end
            1:
            begin
                g_p = '1;
                g_i = '1;
                g_d = '1;
                yl = '0;
                yh = '1;
                pl = '0;
                ph = '1;
            end
            2:
            begin
                g_p = '0;
                g_i = '0;
                g_d = '0;
            end
            3:
            begin
                // Low above high: no move is ever taken on either axis.
                yl = 12'd3000;
                yh = 12'd1000;
                pl = '1;
                ph = '0;
            end
            default: ;
        endcase
        write_reg(CFG_KP, g_p);
        write_reg(CFG_KI, g_i);
        write_reg(CFG_KD, g_d);
        write_reg(CFG_YAW_LOW, GAIN_BITS'(yl));
        write_reg(CFG_YAW_HIGH, GAIN_BITS'(yh));
        write_reg(CFG_PITCH_LOW, GAIN_BITS'(pl));
        write_reg(CFG_PITCH_HIGH, GAIN_BITS'(ph));
        if (phase == 4)
        begin
            junk = {$urandom, $urandom};
            write_reg(CFG_IDX_BITS'(CFG_PITCH_HIGH + 1), junk[GAIN_BITS-1:0]);
        end
    endtask

    function automatic in_t rand_item();
        in_t         v;
        int          pick;
        logic [63:0] raw;
        pick = $urandom_range(99);
        raw = {$urandom, $urandom};
        v = raw[$bits(in_t)-1:0];
        if (pick < 70)
        begin
            v.x_err = $signed(ERROR_BITS'($urandom_range(80))) - 12'sd40;
            v.y_err = $signed(ERROR_BITS'($urandom_range(80))) - 12'sd40;
            v.elapsed_ms = MS_BITS'($urandom_range(60));
        end
        else if (pick < 80)
            v.elapsed_ms = '0;
        return v;
    endfunction

    typedef struct packed {
        in_t  item;
        bit   typed;
        out_t want;
    } row_t;

    row_t directed[] = '{
        '{'{12'sd0, 12'sd0, 16'd7}, 1'b1, '{12'd1500, 12'd1500, 1'b1, 1'b1}},
        '{'{12'sd2047, -12'sd2048, 16'd1}, 1'b0, '0},
        '{'{-12'sd2048, 12'sd2047, 16'd1}, 1'b0, '0},
        '{'{12'sd1, -12'sd1, 16'd0}, 1'b0, '0},
        '{'{-12'sd1, 12'sd1, 16'd65535}, 1'b0, '0},
        '{'{12'sd2047, 12'sd2047, 16'd65535}, 1'b0, '0},
        '{'{-12'sd2048, -12'sd2048, 16'd0}, 1'b0, '0},
        '{'{12'sd0, 12'sd0, 16'd0}, 1'b0, '0},
        '{'{12'sd2047, -12'sd2048, 16'd3}, 1'b0, '0},
        '{'{-12'sd2048, 12'sd2047, 16'd2}, 1'b0, '0},
        '{'{12'sd100, 12'sd100, 16'd33}, 1'b0, '0},
        '{'{-12'sd100, -12'sd100, 16'd33}, 1'b0, '0},
        '{'{12'sd0, 12'sd0, 16'd65535}, 1'b0, '0},
        '{'{12'sd5, -12'sd5, 16'd1}, 1'b0, '0},
        '{'{12'sd0, 12'sd0, 16'd1}, 1'b0, '0}
    };

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        typed_next = 1'b0;
        typed_value = '0;
        fails = 0;
        items_sent = 0;
        results_seen = 0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        kp = KP_RESET;
        ki = KI_RESET;
        kd = KD_RESET;
        yaw_lo = LOW_RESET;
        yaw_hi = HIGH_RESET;
        pitch_lo = LOW_RESET;
        pitch_hi = HIGH_RESET;
        x_last = 0;
        y_last = 0;
        x_acc = 0;
        y_acc = 0;
        yaw_pos = longint'(CENTER_PULSE);
        pitch_pos = longint'(CENTER_PULSE);
        started = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The first row runs on reset defaults, so its result is known outright.
        // The flags update after the monitor has seen the previous acceptance.
        foreach (directed[i])
        begin
            typed_next <= directed[i].typed;
            typed_value <= directed[i].want;
            send_item(directed[i].item);
        end
        drain();
        typed_next = 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_setting(ph);
            quiet_sender = (ph == 5);
            quiet_receiver = (ph == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(rand_item());
            drain();
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;

        $display("covered %0d items and %0d results over %0d register settings",
                 items_sent, results_seen, RANDOM_PHASES + 1);
        $display("settings included saturating gains, zero gains and inverted limits");
        if (fails == 0 && pulse_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
